[rtl/erlb_pkg.sv]
package erlb_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int MAX_READ = 16;
  localparam int DIV_W    = 46;

  // divide by 1000 as a shift by 3, then by 125 in 11-bit digits
  localparam int          DIV_DIGIT_W = 11;
  localparam int          DIV_DIGITS  = 4;
  localparam int          DIV_SHIFT   = 23;
  localparam logic [16:0] DIV_RECIP   = 17'd67109;
  localparam logic [6:0]  DIV_ODD     = 7'd125;

  localparam logic [4:0]              TYPE_LIMIT = 5'd22;
  localparam logic [31:0]             EPOCH_S    = 32'd1704067200;
  localparam logic signed [DIV_W-1:0] EPOCH_MS   = 46'sd1704067200000;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_SYNC   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RADDR,
    S_RDATA,
    S_DIV,
    S_BWRITE,
    S_BEND,
    S_ENTRY,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mem_read;
    logic load_entry;
    logic div_start;
    logic bf_write;
    logic step;
    logic bf_end;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic read_empty;
    logic walk_empty;
    logic walk_last;
    logic qualifies;
    logic div_done;
    logic entry_last;
  } stat_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] boot;
    logic [43:0] uptime;
    logic [4:0]  kind;
    logic [31:0] payload;
  } entry_t;

  function automatic logic [1:0] category_of(input logic [4:0] kind);
    logic [1:0] c;
    case (kind)
      5'd0, 5'd17:                      c = 2'd3;
      5'd1, 5'd2, 5'd3, 5'd4:           c = 2'd2;
      5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
      5'd10, 5'd11, 5'd12, 5'd13, 5'd14: c = 2'd1;
      5'd15, 5'd16, 5'd18, 5'd19,
      5'd20, 5'd21:                     c = 2'd0;
      default:                          c = 2'd3;
    endcase
    return c;
  endfunction

endpackage

[rtl/erlb_if.sv]
interface erlb_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [4:0]  event_type;
  logic [31:0] payload;
  logic [31:0] wall_seconds;
  logic [43:0] boot_ms;
  logic [7:0]  read_offset;
  logic [4:0]  read_count;
  logic [43:0] sync_epoch_ms;
  modport source (output valid, operation, event_type, payload, wall_seconds, boot_ms,
                  read_offset, read_count, sync_epoch_ms, input ready);
  modport sink (input valid, operation, event_type, payload, wall_seconds, boot_ms,
                read_offset, read_count, sync_epoch_ms, output ready);
endinterface

interface erlb_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] log_id;
  logic [31:0] entry_timestamp;
  logic [31:0] entry_boot;
  logic [43:0] entry_uptime;
  logic [4:0]  entry_kind;
  logic [31:0] entry_payload;
  logic [1:0]  entry_category;
  logic [6:0]  updated_count;
  logic [31:0] revision;
  logic [6:0]  stored_count;
  logic        last;
  modport source (output valid, status, log_id, entry_timestamp, entry_boot, entry_uptime,
                  entry_kind, entry_payload, entry_category, updated_count, revision,
                  stored_count, last, input ready);
  modport sink (input valid, status, log_id, entry_timestamp, entry_boot, entry_uptime,
                entry_kind, entry_payload, entry_category, updated_count, revision,
                stored_count, last, output ready);
endinterface

interface erlb_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/erlb_div.sv]
module erlb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [erlb_pkg::DIV_W-1:0] dividend,
  output logic [31:0]                quotient,
  output logic                       done
);
  import erlb_pkg::*;

  localparam int SHIFT_W = DIV_DIGIT_W * DIV_DIGITS;
  localparam int PART_W  = DIV_DIGIT_W + 7;
  localparam int PROD_W  = PART_W + 17;

  logic [6:0]             rem;
  logic [SHIFT_W-1:0]     quo;
  logic [2:0]             steps;
  logic [PART_W-1:0]      part;
  logic [PROD_W-1:0]      prod;
  logic [DIV_DIGIT_W-1:0] qd;
  logic [PART_W-1:0]      qd_x;

  // one base-2048 digit of x/125 per cycle; the reciprocal estimate is exact
  // while a partial dividend stays below 493447, and it never passes 255999
  assign part = {rem, quo[SHIFT_W-1 -: DIV_DIGIT_W]};
  assign prod = PROD_W'(part) * PROD_W'(DIV_RECIP);
  assign qd   = prod[DIV_SHIFT +: DIV_DIGIT_W];
  assign qd_x = PART_W'(qd) * PART_W'(DIV_ODD);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= 3'(DIV_DIGITS);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  // drop the low three bits (divide by 8), then shift quotient digits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= SHIFT_W'(dividend[DIV_W-1:3]);
    end else if (steps != '0) begin
      rem <= 7'(part - qd_x);
      quo <= {quo[SHIFT_W-DIV_DIGIT_W-1:0], qd};
    end
  end

  assign quotient = quo[31:0];
  assign done     = steps == '0;

endmodule

[rtl/erlb_ctrl.sv]
module erlb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  erlb_pkg::stat_t stat,
  output erlb_pkg::cmd_t  cmd
);
  import erlb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        case (stat.op)
          OP_READ: state_next = stat.read_empty ? S_OUT : S_RADDR;
          OP_SYNC: state_next = stat.walk_empty ? S_OUT : S_RADDR;
          default: state_next = S_OUT;
        endcase
      end
      S_RADDR: state_next = S_RDATA;
      S_RDATA: begin
        if (stat.op == OP_READ) begin
          state_next = S_ENTRY;
        end else if (stat.qualifies) begin
          state_next = S_DIV;
        end else begin
          state_next = stat.walk_last ? S_BEND : S_RADDR;
        end
      end
      S_DIV:    if (stat.div_done) state_next = S_BWRITE;
      S_BWRITE: state_next = stat.walk_last ? S_BEND : S_RADDR;
      S_BEND:   state_next = S_OUT;
      S_ENTRY:  if (out_ready) state_next = stat.entry_last ? S_IDLE : S_RADDR;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC:  cmd.exec = 1'b1;
      S_RADDR: cmd.mem_read = 1'b1;
      S_RDATA: begin
        if (stat.op == OP_READ) begin
          cmd.load_entry = 1'b1;
        end else if (stat.qualifies) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_BWRITE: begin
        cmd.bf_write = 1'b1;
        cmd.step     = 1'b1;
      end
      S_BEND: cmd.bf_end = 1'b1;
      S_ENTRY: begin
        out_valid = 1'b1;
        cmd.step  = out_ready && !stat.entry_last;
      end
      S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  a_div_enter: assert property (@(posedge clk) disable iff (rst) cmd.div_start |=> state == S_DIV)
    else $error("divide not entered");
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !stat.div_done) |=> state == S_DIV)
    else $error("divide left early");
`endif

endmodule

[rtl/erlb_dp.sv]
module erlb_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_data,
  input  erlb_pkg::cmd_t  cmd,
  output erlb_pkg::stat_t stat,
  input  logic [1:0]      operation,
  input  logic [4:0]      event_type,
  input  logic [31:0]     payload,
  input  logic [31:0]     wall_seconds,
  input  logic [43:0]     boot_ms,
  input  logic [7:0]      read_offset,
  input  logic [4:0]      read_count,
  input  logic [43:0]     sync_epoch_ms,
  output logic [1:0]      status,
  output logic [31:0]     log_id,
  output logic [31:0]     entry_timestamp,
  output logic [31:0]     entry_boot,
  output logic [43:0]     entry_uptime,
  output logic [4:0]      entry_kind,
  output logic [31:0]     entry_payload,
  output logic [1:0]      entry_category,
  output logic [6:0]      updated_count,
  output logic [31:0]     revision,
  output logic [6:0]      stored_count,
  output logic            last
);
  import erlb_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd;

  op_t         op_q;
  logic [4:0]  type_q;
  logic [31:0] payload_q;
  logic [31:0] wall_q;
  logic [43:0] uptime_q;
  logic [7:0]  offset_q;
  logic [4:0]  count_q;
  logic [43:0] sync_q;

  logic [31:0]       boot_id;
  logic [ADDR_W-1:0] write_slot;
  logic [CNT_W-1:0]  held_count;
  logic [31:0]       next_id;
  logic [31:0]       rev;
  logic [CNT_W-1:0]  walk_n;
  logic [CNT_W-1:0]  walk_i;
  logic [CNT_W-1:0]  upd;
  logic signed [44:0] boot_epoch;

  logic              bad_type;
  logic [4:0]        count_sat;
  logic [CNT_W-1:0]  avail;
  logic [CNT_W-1:0]  read_n;
  logic [ADDR_W-1:0] walk_off;
  logic [ADDR_W-1:0] addr;
  logic [31:0]       id_inc;
  logic signed [DIV_W-1:0] ev;
  logic [31:0]       quotient;
  logic              div_done;
  logic              rec_we;
  entry_t            rec_entry;
  entry_t            bf_entry;

  assign bad_type  = type_q >= TYPE_LIMIT;
  assign count_sat = (count_q > 5'(MAX_READ)) ? 5'(MAX_READ) : count_q;
  assign avail     = CNT_W'({1'b0, held_count} - offset_q);
  assign read_n    = (avail < CNT_W'(count_sat)) ? avail : CNT_W'(count_sat);
  assign walk_off  = (op_q == OP_READ) ? offset_q[ADDR_W-1:0] : '0;
  assign addr      = write_slot - 1'b1 - walk_off - walk_i[ADDR_W-1:0];
  assign id_inc    = next_id + 1'b1;
  assign ev        = DIV_W'(boot_epoch) + $signed({2'b00, rd.uptime});
  assign rec_we    = cmd.exec && op_q == OP_RECORD && !bad_type;

  assign stat.op         = op_q;
  assign stat.read_empty = count_q == '0 || {1'b0, offset_q} >= 9'(held_count);
  assign stat.walk_empty = held_count == '0;
  assign stat.walk_last  = walk_i + 1'b1 == walk_n;
  assign stat.qualifies  = rd.boot == boot_id && rd.stamp == '0 && ev >= EPOCH_MS;
  assign stat.div_done   = div_done;
  assign stat.entry_last = last;

  always_comb begin
    rec_entry.stamp   = (wall_q < EPOCH_S) ? '0 : wall_q;
    rec_entry.boot    = boot_id;
    rec_entry.uptime  = uptime_q;
    rec_entry.kind    = type_q;
    rec_entry.payload = payload_q;
    bf_entry          = rd;
    bf_entry.stamp    = quotient;
  end

  erlb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (DIV_W'(ev)),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rec_we) begin
      mem[write_slot] <= rec_entry;
    end else if (cmd.bf_write) begin
      mem[addr] <= bf_entry;
    end
    if (cmd.mem_read) begin
      rd <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= op_t'(operation);
      type_q    <= event_type;
      payload_q <= payload;
      wall_q    <= wall_seconds;
      uptime_q  <= boot_ms;
      offset_q  <= read_offset;
      count_q   <= read_count;
      sync_q    <= sync_epoch_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_id    <= 32'd1;
      write_slot <= '0;
      held_count <= '0;
      next_id    <= 32'd1;
      rev        <= '0;
      walk_n     <= '0;
      walk_i     <= '0;
      upd        <= '0;
    end else begin
      if (cfg_we) boot_id <= cfg_data;
      if (cmd.exec) begin
        walk_i <= '0;
        upd    <= '0;
        case (op_q)
          OP_RECORD: begin
            if (!bad_type) begin
              next_id    <= (id_inc == '0) ? 32'd1 : id_inc;
              write_slot <= write_slot + 1'b1;
              if (held_count < CNT_W'(DEPTH)) held_count <= held_count + 1'b1;
              rev <= rev + 1'b1;
            end
          end
          OP_READ: walk_n <= read_n;
          OP_SYNC: walk_n <= held_count;
          OP_CLEAR: begin
            write_slot <= '0;
            held_count <= '0;
            rev        <= rev + 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.step) walk_i <= walk_i + 1'b1;
      if (cmd.bf_write) upd <= upd + 1'b1;
      if (cmd.bf_end && upd != '0) rev <= rev + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      boot_epoch <= $signed({1'b0, sync_q}) - $signed({1'b0, uptime_q});
    end
  end

  // result register: terminal results on exec and backfill end, entries on load
  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.bf_end || cmd.load_entry) begin
      status          <= ST_OK;
      log_id          <= '0;
      entry_timestamp <= '0;
      entry_boot      <= '0;
      entry_uptime    <= '0;
      entry_kind      <= '0;
      entry_payload   <= '0;
      entry_category  <= '0;
      updated_count   <= '0;
      revision        <= rev;
      stored_count    <= held_count;
      last            <= 1'b1;
      if (cmd.exec) begin
        case (op_q)
          OP_RECORD: begin
            if (bad_type) begin
              status <= ST_BAD_TYPE;
            end else begin
              log_id   <= next_id;
              revision <= rev + 1'b1;
              if (held_count < CNT_W'(DEPTH)) stored_count <= held_count + 1'b1;
            end
          end
          OP_READ: status <= ST_EMPTY;
          OP_CLEAR: begin
            revision     <= rev + 1'b1;
            stored_count <= '0;
          end
          default: ;
        endcase
      end else if (cmd.bf_end) begin
        updated_count <= upd;
        if (upd != '0) revision <= rev + 1'b1;
      end else begin
        entry_timestamp <= rd.stamp;
        entry_boot      <= rd.boot;
        entry_uptime    <= rd.uptime;
        entry_kind      <= rd.kind;
        entry_payload   <= rd.payload;
        entry_category  <= category_of(rd.kind);
        last            <= stat.walk_last;
      end
    end
  end

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk) disable iff (rst) held_count <= CNT_W'(DEPTH))
    else $error("held count above depth");
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst) next_id != '0)
    else $error("event id reached zero");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_read |-> walk_i < walk_n)
    else $error("walk past its end");
`endif

endmodule

[rtl/event_ring_log_backfill_unit.sv]
// channel | dir | carries
// cmd     | in  | operation, event_type, payload, wall_seconds, boot_ms, read/sync fields
// rsp     | out | status, log_id, entry fields, updated_count, revision, stored_count, last
// cfg     | in  | boot_id write data
// One item at a time. Record, clear, empty reads and an empty backfill go through the exec
// and out states, and the out state holds while rsp stalls. A read does one memory read per entry.
// Backfill reads each held entry once and runs the divider for each entry whose stamp is filled
// in (divide by 1000 in four 11-bit digit steps) before that stamp is written back.
// Reset is synchronous; the log comes out empty, boot id 1. rsp stalls hold a read walk.
module event_ring_log_backfill_unit (
  input logic clk,
  input logic rst,
  erlb_cmd_if.sink   cmd,
  erlb_rsp_if.source rsp,
  erlb_cfg_if.sink   cfg
);
  import erlb_pkg::*;

  cmd_t  ctl_cmd;
  stat_t ctl_stat;

  assign cfg.ready = 1'b1;

  erlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (ctl_stat),
    .cmd       (ctl_cmd)
  );

  erlb_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.data),
    .cmd             (ctl_cmd),
    .stat            (ctl_stat),
    .operation       (cmd.operation),
    .event_type      (cmd.event_type),
    .payload         (cmd.payload),
    .wall_seconds    (cmd.wall_seconds),
    .boot_ms         (cmd.boot_ms),
    .read_offset     (cmd.read_offset),
    .read_count      (cmd.read_count),
    .sync_epoch_ms   (cmd.sync_epoch_ms),
    .status          (rsp.status),
    .log_id          (rsp.log_id),
    .entry_timestamp (rsp.entry_timestamp),
    .entry_boot      (rsp.entry_boot),
    .entry_uptime    (rsp.entry_uptime),
    .entry_kind      (rsp.entry_kind),
    .entry_payload   (rsp.entry_payload),
    .entry_category  (rsp.entry_category),
    .updated_count   (rsp.updated_count),
    .revision        (rsp.revision),
    .stored_count    (rsp.stored_count),
    .last            (rsp.last)
  );

endmodule
